@@ src/mi3_pkg.sv @@
// Shared types, widths and constants of the 3x3 matrix inverse.
// No dependencies; every module of the block imports this package.
package mi3_pkg;

    localparam int EW       = 32;
    localparam int N        = 9;
    localparam int AW       = 64;
    localparam int DW       = 98;
    localparam int DMW      = 97;
    localparam int QW       = 32;
    localparam int HALF     = 32;
    localparam int COLS     = 3;
    localparam int ADJ_LAT  = 6;
    localparam int LANE_LAT = QW + 2;
    localparam int LAT      = ADJ_LAT + LANE_LAT + 1;
    localparam int ONE_SHIFT = 48;

    typedef logic signed [EW-1:0] elem_t;
    typedef logic signed [AW-1:0] adj_t;
    typedef logic [DMW-1:0]       dmag_t;
    typedef logic [3:0]           idx_t;

    typedef struct packed {
        dmag_t dmag;
        logic  dneg;
        logic  sing;
    } det_info_t;

    localparam dmag_t SING_DMAG = DMW'(1) << ONE_SHIFT;
    localparam logic [EW-1:0] POS_SAT = {1'b0, {(EW-1){1'b1}}};
    localparam logic [EW-1:0] NEG_SAT = {1'b1, {(EW-1){1'b0}}};

    // Each adjugate entry is m[PA_A]*m[PA_B] - m[PB_A]*m[PB_B], flat row-major indexes.
    localparam idx_t PA_A [N] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
    localparam idx_t PA_B [N] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
    localparam idx_t PB_A [N] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
    localparam idx_t PB_B [N] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

    // First-column elements used in the determinant expansion.
    localparam idx_t COL0 [COLS] = '{4'd0, 4'd3, 4'd6};

endpackage

@@ src/matrix_inverse_3x3.sv @@
// Top level of the 3x3 matrix inverse: input unpacking, nine division lanes,
// merging output register and handshake. Depends on mi3_pkg, mi3_adjdet, mi3_div_lane.
//
// The block accepts one matrix per clock cycle while the output is not held off. The
// adjugate and the exact determinant are formed first, and each of nine parallel
// lanes then passes its entry through a 32-stage restoring divider that yields one
// quotient bit per stage, followed by saturation and the merging output register.
// Results leave in input order; when the output is held off, the whole pipeline
// holds and s_axis_tready falls.
module matrix_inverse_3x3 import mi3_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [N*EW-1:0] s_axis_tdata,  // m00, m01, m02, m10, m11, m12, m20, m21, m22
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [N*EW-1:0] m_axis_tdata,  // r00, r01, r02, r10, r11, r12, r20, r21, r22
    output logic            m_axis_tuser   // singular
);

    logic [LAT-1:0]      vld_reg;
    logic [LAT-1:0]      vld_next;
    logic                en;
    elem_t               m [N];
    adj_t                adj [N];
    det_info_t           info;
    dmag_t               dm_reg [QW];
    logic [LANE_LAT-1:0] sing_reg;
    logic [EW-1:0]       res [N];
    logic [N*EW-1:0]     tdata_reg;
    logic                tuser_reg;

    assign en = !vld_reg[LAT-1] || m_axis_tready;

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            m[i] = s_axis_tdata[i*EW +: EW];
        end
        vld_next = en ? {vld_reg[LAT-2:0], s_axis_tvalid} : vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    mi3_adjdet u_adjdet
    (
        .clk  (clk),
        .en   (en),
        .m    (m),
        .adj  (adj),
        .info (info)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dm_reg[0] <= info.dmag;
            for (int k = 1; k < QW; k++)
            begin
                dm_reg[k] <= dm_reg[k-1];
            end
            sing_reg <= {sing_reg[LANE_LAT-2:0], info.sing};
            for (int i = 0; i < N; i++)
            begin
                tdata_reg[i*EW +: EW] <= res[i];
            end
            tuser_reg <= sing_reg[LANE_LAT-1];
        end
    end

    for (genvar g = 0; g < N; g++)
    begin : g_lane
        mi3_div_lane u_lane
        (
            .clk     (clk),
            .en      (en),
            .adj     (adj[g]),
            .info    (info),
            .dm_pipe (dm_reg),
            .res     (res[g])
        );
    end

    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[LAT-1];
    assign m_axis_tdata  = tdata_reg;
    assign m_axis_tuser  = tuser_reg;

    a_sing_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ADJ_LAT-1] && info.sing |-> info.dmag == SING_DMAG && !info.dneg)
        else $error("Singular matrix without a unit divisor.");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ADJ_LAT-1] |-> info.dmag != '0)
        else $error("Zero divisor reached the division lanes.");

    a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(sing_reg) && $stable(vld_reg))
        else $error("Pipeline moved while the output transfer was held off.");

endmodule

@@ src/mi3_adjdet.sv @@
// Adjugate and determinant pipeline of the 3x3 matrix inverse.
// Depends on mi3_pkg; feeds the division lanes.
module mi3_adjdet import mi3_pkg::*;
(
    input  logic      clk,
    input  logic      en,
    input  elem_t     m [N],
    output adj_t      adj [N],
    output det_info_t info
);

    adj_t                 pa_reg [N];
    adj_t                 pb_reg [N];
    elem_t                c1_reg [COLS];
    elem_t                c2_reg [COLS];
    adj_t                 adj2_reg [N];
    adj_t                 adj3_reg [N];
    adj_t                 adj4_reg [N];
    adj_t                 adj5_reg [N];
    adj_t                 adj6_reg [N];
    logic signed [AW-1:0] ph_reg [COLS];
    logic signed [AW:0]   pl_reg [COLS];
    logic signed [DW-1:0] term_reg [COLS];
    logic signed [DW-1:0] det_reg;
    det_info_t            info_reg;
    logic signed [DW-1:0] det_abs;

    always_comb
    begin
        det_abs = det_reg[DW-1] ? -det_reg : det_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < N; i++)
            begin
                pa_reg[i]   <= AW'(m[PA_A[i]]) * AW'(m[PA_B[i]]);
                pb_reg[i]   <= AW'(m[PB_A[i]]) * AW'(m[PB_B[i]]);
                adj2_reg[i] <= pa_reg[i] - pb_reg[i];
                adj3_reg[i] <= adj2_reg[i];
                adj4_reg[i] <= adj3_reg[i];
                adj5_reg[i] <= adj4_reg[i];
                adj6_reg[i] <= adj5_reg[i];
            end
            for (int j = 0; j < COLS; j++)
            begin
                c1_reg[j]   <= m[COL0[j]];
                c2_reg[j]   <= c1_reg[j];
                ph_reg[j]   <= AW'(c2_reg[j]) * AW'($signed(adj2_reg[j][AW-1:HALF]));
                pl_reg[j]   <= (AW+1)'(c2_reg[j])
                               * (AW+1)'($signed({1'b0, adj2_reg[j][HALF-1:0]}));
                term_reg[j] <= (DW'(ph_reg[j]) <<< HALF) + DW'(pl_reg[j]);
            end
            det_reg <= term_reg[0] + term_reg[1] + term_reg[2];
            if (det_reg == '0)
            begin
                info_reg.sing <= 1'b1;
                info_reg.dneg <= 1'b0;
                info_reg.dmag <= SING_DMAG;
            end
            else
            begin
                info_reg.sing <= 1'b0;
                info_reg.dneg <= det_reg[DW-1];
                info_reg.dmag <= det_abs[DMW-1:0];
            end
        end
    end

    assign adj  = adj6_reg;
    assign info = info_reg;

endmodule

@@ src/mi3_div_lane.sv @@
// One division lane: adjugate entry times 2^32 over the determinant magnitude,
// restoring division one quotient bit per stage, then saturation. Depends on mi3_pkg.
module mi3_div_lane import mi3_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  adj_t        adj,
    input  det_info_t   info,
    input  dmag_t       dm_pipe [QW],
    output logic [EW-1:0] res
);

    dmag_t           rem_reg [QW+1];
    logic [QW-1:0]   q_reg [QW+1];
    logic            neg_reg [QW+1];
    logic            ovf_reg [QW+1];
    dmag_t           rem_next [QW+1];
    logic [QW-1:0]   q_next [QW+1];
    logic [AW-1:0]   cm;
    logic [DMW:0]    shifted;
    logic            ge;
    logic [EW-1:0]   res_reg;
    logic [EW-1:0]   res_next;

    always_comb
    begin
        cm          = adj[AW-1] ? (~adj + 1'b1) : adj;
        rem_next[0] = DMW'(cm);
        q_next[0]   = '0;
        shifted     = '0;
        ge          = 1'b0;
        for (int k = 1; k <= QW; k++)
        begin
            shifted = {rem_reg[k-1], 1'b0};
            ge      = shifted >= {1'b0, dm_pipe[k-1]};
            rem_next[k] = ge ? DMW'(shifted - {1'b0, dm_pipe[k-1]}) : DMW'(shifted);
            q_next[k]   = {q_reg[k-1][QW-2:0], ge};
        end
    end

    always_comb
    begin
        if (!neg_reg[QW])
        begin
            res_next = (ovf_reg[QW] || q_reg[QW] > POS_SAT) ? POS_SAT : q_reg[QW];
        end
        else
        begin
            res_next = (ovf_reg[QW] || q_reg[QW] > NEG_SAT) ? NEG_SAT : (~q_reg[QW] + 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= rem_next[0];
            q_reg[0]   <= q_next[0];
            neg_reg[0] <= adj[AW-1] ^ info.dneg;
            ovf_reg[0] <= DMW'(cm) >= info.dmag;
            for (int k = 1; k <= QW; k++)
            begin
                rem_reg[k] <= rem_next[k];
                q_reg[k]   <= q_next[k];
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule
